// ===== hw/rtl/ipv4_header_checker_defines.svh =====
// ----------------------------------------------------------------------------
// IPv4 header checker assertion macros
// Shared assertion wrappers, clocked on clk_i with the active-low reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECKER_DEFINES_SVH
`define IPV4_HEADER_CHECKER_DEFINES_SVH

// Checked only while out of reset.
`define IHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define IHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Shared constants, types and the one's-complement adder.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned CountW      = $clog2(HeaderBytes + 1);
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [15:0] SumGood          = 16'hFFFF;
  localparam logic [31:0] LocalAddrReset   = 32'h0A00_0002;
  localparam logic [31:0] BcastAddrReset   = 32'h0A00_00FF;
  localparam logic [7:0]  ProtoReset       = 8'h11;

  localparam logic [CountW-1:0] IdxLenHi   = CountW'(2);
  localparam logic [CountW-1:0] IdxLenLo   = CountW'(3);
  localparam logic [CountW-1:0] IdxProto   = CountW'(9);
  localparam logic [CountW-1:0] IdxSrcFirst = CountW'(12);
  localparam logic [CountW-1:0] IdxSrcLast  = CountW'(15);
  localparam logic [CountW-1:0] IdxDstFirst = CountW'(16);
  localparam logic [CountW-1:0] IdxDstLast  = CountW'(19);
  localparam logic [CountW-1:0] IdxLast     = CountW'(HeaderBytes - 1);
  localparam logic [CountW-1:0] CountFull   = CountW'(HeaderBytes);

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_BAD_SUM   = 2'd1,
    VERDICT_BAD_DEST  = 2'd2,
    VERDICT_BAD_PROTO = 2'd3
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOCAL_ADDR = 2'd0,
    CFG_BCAST_ADDR = 2'd1,
    CFG_PROTOCOL   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] broadcast_address;
    logic [7:0]  accepted_protocol;
  } ihc_cfg_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } ihc_result_t;

  typedef struct packed {
    logic out_valid;
    logic skid_full;
  } ihc_buf_status_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// ===== hw/rtl/ihc_parse.sv =====
// ----------------------------------------------------------------------------
// IPv4 header parser
// Keeps the octet count, checksum and captured fields, and forms the verdict
// on the last header octet.
// ----------------------------------------------------------------------------
module ihc_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          header_byte_i,
  input  logic                first_byte_i,
  input  ihc_pkg::ihc_cfg_t   cfg_i,
  output logic                res_valid_o,
  output ihc_pkg::ihc_result_t res_o
);
  import ihc_pkg::*;

  logic [CountW-1:0] count_q, count_d, cnt;
  logic [15:0]       sum_q, sum_d, sum_base, sum_final;
  logic [7:0]        pend_q, pend_d, pend_base;
  logic [15:0]       len_q, len_d;
  logic [7:0]        proto_q, proto_d;
  logic [31:0]       src_q, src_d;
  logic [31:0]       dst_q, dst_d;
  logic              active;
  logic              last;

  always_comb begin
    cnt       = first_byte_i ? '0 : count_q;
    sum_base  = first_byte_i ? '0 : sum_q;
    pend_base = first_byte_i ? '0 : pend_q;
    active    = accept_i && (cnt < CountFull);
    last      = active && (cnt == IdxLast);

    count_d = count_q;
    sum_d   = sum_q;
    pend_d  = pend_q;
    len_d   = len_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;

    if (active) begin
      count_d = cnt + CountW'(1);
      if (cnt[0]) begin
        sum_d  = oc_add(sum_base, {pend_base, header_byte_i});
        pend_d = pend_base;
      end else begin
        sum_d  = sum_base;
        pend_d = header_byte_i;
      end
      if (cnt == IdxLenHi || cnt == IdxLenLo) begin
        len_d = {len_q[7:0], header_byte_i};
      end else if (cnt == IdxProto) begin
        proto_d = header_byte_i;
      end else if (cnt >= IdxSrcFirst && cnt <= IdxSrcLast) begin
        src_d = {src_q[23:0], header_byte_i};
      end else if (cnt >= IdxDstFirst && cnt <= IdxDstLast) begin
        dst_d = {dst_q[23:0], header_byte_i};
      end
    end else if (accept_i && first_byte_i) begin
      count_d = cnt;
      sum_d   = sum_base;
      pend_d  = pend_base;
    end

    // A lone final octet of an odd-length header pads with a zero low octet.
    sum_final = cnt[0] ? sum_d : oc_add(sum_d, {header_byte_i, 8'h00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      len_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= last ? sum_final : sum_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

  always_comb begin
    res_valid_o           = last;
    res_o.total_length    = len_d;
    res_o.protocol_number = proto_d;
    res_o.source_address  = src_d;
    res_o.dest_address    = dst_d;
    if (sum_final != SumGood) begin
      res_o.verdict = VERDICT_BAD_SUM;
    end else if (dst_d != cfg_i.local_address && dst_d != cfg_i.broadcast_address) begin
      res_o.verdict = VERDICT_BAD_DEST;
    end else if (proto_d != cfg_i.accepted_protocol) begin
      res_o.verdict = VERDICT_BAD_PROTO;
    end else begin
      res_o.verdict = VERDICT_OK;
    end
  end

endmodule

// ===== hw/rtl/ihc_outbuf.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker result buffer
// Output register with one skid entry, so the input side keeps taking octets
// while a finished word waits.
// ----------------------------------------------------------------------------
module ihc_outbuf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ihc_pkg::ihc_result_t    push_data_i,
  input  logic                    out_stall_i,
  output ihc_pkg::ihc_result_t    out_data_o,
  output ihc_pkg::ihc_buf_status_t status_o
);
  import ihc_pkg::*;

  ihc_result_t out_q, out_d, skid_q, skid_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        out_free;

  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_data_o         = out_q;
  assign status_o.out_valid = out_valid_q;
  assign status_o.skid_full = skid_valid_q;

endmodule

// ===== hw/rtl/ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker
// Verifies the one's-complement checksum of a fixed-length IPv4 header taken
// one octet per word, checks destination and protocol, and reports a verdict
// with the captured length, protocol and addresses.
//
//   Channel  Direction  Handshake                 Word
//   in       input      in_valid_i / in_stall_o   header_byte_i, first_byte_i
//   out      output     out_valid_o / out_stall_i verdict and captured fields
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One octet is taken per cycle while in_stall_o is low. The parser state and
// checksum adder form the verdict on the last header octet; the output
// register, or its skid entry while the output stalls, registers it. Reset
// restores the default addresses and protocol and clears the octet count.
// in_stall_o rises only when output and skid entries hold unread results.
// ----------------------------------------------------------------------------
`include "ipv4_header_checker_defines.svh"

module ipv4_header_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  header_byte_i,
  input  logic                        first_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ihc_pkg::verdict_e           verdict_o,
  output logic [15:0]                 total_length_o,
  output logic [7:0]                  protocol_number_o,
  output logic [31:0]                 source_address_o,
  output logic [31:0]                 dest_address_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ihc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import ihc_pkg::*;

  ihc_cfg_t        cfg_q, cfg_d;
  ihc_result_t     res, out_data;
  ihc_buf_status_t buf_status;
  logic            res_valid;
  logic            in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LOCAL_ADDR: cfg_d.local_address     = cfg_data_i;
        CFG_BCAST_ADDR: cfg_d.broadcast_address = cfg_data_i;
        CFG_PROTOCOL:   cfg_d.accepted_protocol = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_address     <= LocalAddrReset;
      cfg_q.broadcast_address <= BcastAddrReset;
      cfg_q.accepted_protocol <= ProtoReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ihc_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .header_byte_i (header_byte_i),
    .first_byte_i  (first_byte_i),
    .cfg_i         (cfg_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ihc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data),
    .status_o    (buf_status)
  );

  assign in_stall_o        = buf_status.skid_full;
  assign out_valid_o       = buf_status.out_valid;
  assign verdict_o         = out_data.verdict;
  assign total_length_o    = out_data.total_length;
  assign protocol_number_o = out_data.protocol_number;
  assign source_address_o  = out_data.source_address;
  assign dest_address_o    = out_data.dest_address;

  `IHC_ASSERT_ALWAYS(a_result_needs_accept, res_valid |-> in_accept, "result without an accepted octet")
  `IHC_ASSERT(a_skid_implies_out, in_stall_o |-> out_valid_o, "skid entry full while output empty")
  `IHC_ASSERT(a_skid_fill_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i && res_valid), "skid filled without a blocked result")

endmodule
